>>> sv/idle_timeout_deadline_queue_top_defines.svh
// Assertion macros used by the deadline queue engine.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef IDLE_TIMEOUT_DEADLINE_QUEUE_TOP_DEFINES_SVH
`define IDLE_TIMEOUT_DEADLINE_QUEUE_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define IDTQ_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("idtq assertion failed");

// Consequence that must hold in the cycle after the antecedent.
`define IDTQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("idtq assertion failed");

`endif

>>> sv/idtq_pkg.sv
// Types and constants of the deadline queue.
// No dependencies; used by the engine and the top level.
package idtq_pkg;

	localparam int QUEUE_DEPTH  = 64;
	localparam int CONN_ID_BITS = 16;

	localparam int CONN_W  = (CONN_ID_BITS < 16) ? CONN_ID_BITS : 16;
	localparam int SLOT_AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		MODE_ADD   = 2'd0,
		MODE_DEL   = 2'd1,
		MODE_POLL  = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	localparam logic CFG_WAIT_TIME = 1'b0;
	localparam logic CFG_KICK      = 1'b1;

	typedef struct packed {
		logic [15:0] wait_time;
		logic        kick;
	} cfg_t;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] conn_id;
		logic [31:0] seq;
		logic [31:0] now_time;
	} item_t;

	typedef struct packed {
		logic [31:0]       deadline;
		logic [CONN_W-1:0] conn;
		logic [31:0]       seq;
	} slot_t;

	typedef struct packed {
		logic [CONN_W-1:0] conn;
		logic [31:0]       seq;
	} rep_t;

	typedef struct packed {
		logic [15:0] conn_id_out;
		logic [31:0] sequence_out;
		logic        expired;
		logic        last;
		logic        status;
		logic [6:0]  queue_count;
		logic [31:0] earliest_time;
	} res_t;

endpackage

>>> sv/idtq_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Generic; no package dependency.
module idtq_ram #(
	parameter int DATA_W = 8,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/idtq_engine.sv
// Sequencer of the deadline queue: sorted circular slot table and report buffer.
// Depends on idtq_pkg, idtq_ram and the assertion macro header.
`include "idle_timeout_deadline_queue_top_defines.svh"

module idtq_engine
	import idtq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  res_valid,
	input  logic  res_ready,
	output res_t  res
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_INS, ST_INS_PUT, ST_DEL, ST_POLL_RD, ST_POLL_CHK,
		ST_FIN, ST_FIN2, ST_EM_RD, ST_EM_WR, ST_EM_ONE
	} state_t;

	localparam logic [CNT_W-1:0] DEPTH = CNT_W'(QUEUE_DEPTH);
	localparam logic [CNT_W-1:0] ONE   = CNT_W'(1);

	state_t             state_q;
	logic [SLOT_AW-1:0] head_q;
	logic [CNT_W-1:0]   cnt_q, i_q, w_q, budget_q, nres_q, j_q;
	logic [31:0]        head_dl_q, dl_q, now_q;
	logic [CONN_W-1:0]  tconn_q, ins_conn_q;
	logic [31:0]        ins_seq_q;
	logic               status_q, ret_poll_q;

	logic               sl_we, sl_re, rs_we, rs_re;
	logic [SLOT_AW-1:0] sl_waddr, sl_raddr, rs_waddr, rs_raddr;
	slot_t              sl_wdata, sl_rdata, new_ent;
	rep_t               rs_wdata, rs_rdata;
	logic [32:0]        dl_sum;
	logic [CONN_W-1:0]  in_conn;
	logic               accept, rd_later, rd_due, rd_keep;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign dl_sum   = {1'b0, in_item.now_time} + {17'b0, cfg.wait_time};
	assign in_conn  = in_item.conn_id[CONN_W-1:0];
	assign new_ent  = '{deadline: dl_q, conn: ins_conn_q, seq: ins_seq_q};
	assign rd_later = sl_rdata.deadline > dl_q;
	assign rd_due   = sl_rdata.deadline <= now_q;
	assign rd_keep  = sl_rdata.conn != tconn_q;

	idtq_ram #(.DATA_W($bits(slot_t)), .ADDR_W(SLOT_AW)) u_slots (
		.clk, .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
		.re(sl_re), .raddr(sl_raddr), .rdata(sl_rdata)
	);

	idtq_ram #(.DATA_W($bits(rep_t)), .ADDR_W(SLOT_AW)) u_reports (
		.clk, .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
		.re(rs_re), .raddr(rs_raddr), .rdata(rs_rdata)
	);

	// Memory port control. Reads always run ahead of writes at distinct slots.
	always_comb begin
		sl_we    = 1'b0;
		sl_waddr = head_q;
		sl_wdata = sl_rdata;
		sl_re    = 1'b0;
		sl_raddr = head_q;
		rs_we    = 1'b0;
		rs_waddr = nres_q[SLOT_AW-1:0];
		rs_wdata = '{conn: sl_rdata.conn, seq: sl_rdata.seq};
		rs_re    = 1'b0;
		rs_raddr = j_q[SLOT_AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_item.mode == MODE_ADD && cnt_q != '0 && cnt_q != DEPTH) begin
						sl_re    = 1'b1;
						sl_raddr = head_q + SLOT_AW'(cnt_q - ONE);
					end else if (in_item.mode == MODE_DEL && cnt_q != '0) begin
						sl_re = 1'b1;
					end
				end
			end
			ST_INS: begin
				sl_we    = 1'b1;
				sl_waddr = head_q + SLOT_AW'(i_q + ONE);
				if (rd_later) begin
					if (i_q != '0) begin
						sl_re    = 1'b1;
						sl_raddr = head_q + SLOT_AW'(i_q - ONE);
					end
				end else begin
					sl_wdata = new_ent;
				end
			end
			ST_INS_PUT: begin
				sl_we    = 1'b1;
				sl_wdata = new_ent;
			end
			ST_DEL: begin
				sl_we    = rd_keep;
				sl_waddr = head_q + SLOT_AW'(w_q);
				if (i_q + ONE != cnt_q) begin
					sl_re    = 1'b1;
					sl_raddr = head_q + SLOT_AW'(i_q + ONE);
				end
			end
			ST_POLL_RD: begin
				sl_re = (budget_q != '0) && (cnt_q != '0);
			end
			ST_POLL_CHK: begin
				if (rd_due) begin
					rs_we = 1'b1;
					if (!cfg.kick && cnt_q > ONE) begin
						sl_re    = 1'b1;
						sl_raddr = head_q + SLOT_AW'(cnt_q - ONE);
					end
				end
			end
			ST_FIN:  sl_re = 1'b1;
			ST_EM_RD: rs_re = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			cnt_q      <= '0;
			head_dl_q  <= '0;
			i_q        <= '0;
			w_q        <= '0;
			budget_q   <= '0;
			nres_q     <= '0;
			j_q        <= '0;
			status_q   <= 1'b0;
			ret_poll_q <= 1'b0;
			dl_q       <= '0;
			now_q      <= '0;
			tconn_q    <= '0;
			ins_conn_q <= '0;
			ins_seq_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						dl_q       <= dl_sum[32] ? '1 : dl_sum[31:0];
						now_q      <= in_item.now_time;
						tconn_q    <= in_conn;
						ins_conn_q <= in_conn;
						ins_seq_q  <= in_item.seq;
						status_q   <= 1'b0;
						nres_q     <= '0;
						ret_poll_q <= 1'b0;
						i_q        <= '0;
						w_q        <= '0;
						unique case (in_item.mode)
							MODE_ADD: begin
								if (cnt_q == DEPTH) begin
									status_q <= 1'b1;
									state_q  <= ST_FIN;
								end else if (cnt_q == '0) begin
									state_q <= ST_INS_PUT;
								end else begin
									i_q     <= cnt_q - ONE;
									state_q <= ST_INS;
								end
							end
							MODE_DEL: state_q <= (cnt_q == '0) ? ST_FIN : ST_DEL;
							MODE_POLL: begin
								budget_q   <= cnt_q;
								ret_poll_q <= 1'b1;
								state_q    <= ST_POLL_RD;
							end
							MODE_CLEAR: begin
								cnt_q   <= '0;
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_INS: begin
					if (rd_later) begin
						if (i_q == '0) begin
							state_q <= ST_INS_PUT;
						end else begin
							i_q <= i_q - ONE;
						end
					end else begin
						cnt_q   <= cnt_q + ONE;
						state_q <= ret_poll_q ? ST_POLL_RD : ST_FIN;
					end
				end
				ST_INS_PUT: begin
					cnt_q   <= cnt_q + ONE;
					state_q <= ret_poll_q ? ST_POLL_RD : ST_FIN;
				end
				ST_DEL: begin
					if (rd_keep) begin
						w_q <= w_q + ONE;
					end
					if (i_q + ONE == cnt_q) begin
						cnt_q   <= w_q + (rd_keep ? ONE : '0);
						state_q <= ST_FIN;
					end else begin
						i_q <= i_q + ONE;
					end
				end
				ST_POLL_RD: begin
					state_q <= (budget_q == '0 || cnt_q == '0) ? ST_FIN : ST_POLL_CHK;
				end
				ST_POLL_CHK: begin
					if (rd_due) begin
						nres_q     <= nres_q + ONE;
						budget_q   <= budget_q - ONE;
						head_q     <= head_q + SLOT_AW'(1);
						cnt_q      <= cnt_q - ONE;
						ins_conn_q <= sl_rdata.conn;
						ins_seq_q  <= sl_rdata.seq;
						if (cfg.kick) begin
							state_q <= ST_POLL_RD;
						end else if (cnt_q == ONE) begin
							state_q <= ST_INS_PUT;
						end else begin
							i_q     <= cnt_q - CNT_W'(2);
							state_q <= ST_INS;
						end
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: state_q <= ST_FIN2;
				ST_FIN2: begin
					if (cnt_q != '0) begin
						head_dl_q <= sl_rdata.deadline;
					end
					j_q     <= '0;
					state_q <= (nres_q == '0) ? ST_EM_ONE : ST_EM_RD;
				end
				ST_EM_RD: state_q <= ST_EM_WR;
				ST_EM_WR: begin
					if (res_ready) begin
						if (j_q + ONE == nres_q) begin
							state_q <= ST_IDLE;
						end else begin
							j_q     <= j_q + ONE;
							state_q <= ST_EM_RD;
						end
					end
				end
				ST_EM_ONE: if (res_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		res_valid         = (state_q == ST_EM_WR) || (state_q == ST_EM_ONE);
		res.queue_count   = 7'(cnt_q);
		res.earliest_time = (cnt_q == '0) ? '0 : head_dl_q;
		res.status        = status_q;
		if (state_q == ST_EM_WR) begin
			res.conn_id_out  = 16'(rs_rdata.conn);
			res.sequence_out = rs_rdata.seq;
			res.expired      = 1'b1;
			res.last         = (j_q + ONE == nres_q);
		end else begin
			res.conn_id_out  = '0;
			res.sequence_out = '0;
			res.expired      = 1'b0;
			res.last         = 1'b1;
		end
	end

	`IDTQ_ASSERT(a_cnt_bound, cnt_q <= DEPTH)
	`IDTQ_ASSERT(a_plain_is_last, !(res_valid && !res.expired) || res.last)
	`IDTQ_ASSERT_NEXT(a_clear_empties, accept && in_item.mode == MODE_CLEAR, cnt_q == '0)
	`IDTQ_ASSERT_NEXT(a_reports_bounded, state_q == ST_FIN2, nres_q <= DEPTH)

endmodule

>>> sv/idle_timeout_deadline_queue_top.sv
// Top level of the idle timeout deadline queue: ports, registers, result register.
// Depends on idtq_pkg and idtq_engine.

// The block keeps up to QUEUE_DEPTH connection deadlines in ascending order
// (ties in arrival order) in a circular table held in a registered-read synchronous
// RAM, plus a second RAM that buffers the entries reported by a poll so that
// every result can carry the final queue_count and earliest_time of its
// transaction. One input transaction is handled at a time. An add walks the
// stored entries with a later deadline, one read-shift-write per cycle; a delete
// makes one compacting pass; a poll checks entries from the head, runs the
// insertion walk for every re-queued entry, then sends its reported results.
// Results leave through an output register, so the next input transaction is
// accepted while the last result still waits for m_tready.
module idle_timeout_deadline_queue_top
	import idtq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// mode[1:0], conn_id[17:2], sequence_req[49:18], now_time[81:50], zero fill
	input  logic [87:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// conn_id_out[15:0], sequence_out[47:16], expired[48], status[49],
	// queue_count[56:50], earliest_time[88:57], zero fill
	output logic [95:0] m_tdata,
	output logic        m_tlast
);

	cfg_t  cfg_q;
	item_t item;
	res_t  res, res_q;
	logic  res_valid, res_ready, m_tvalid_q;

	// Config regs, written by the user only while the block is idle; unchecked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wait_time <= 16'd20;
			cfg_q.kick      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WAIT_TIME: cfg_q.wait_time <= cfg_data;
				CFG_KICK:      cfg_q.kick      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign item.mode     = mode_t'(s_tdata[1:0]);
	assign item.conn_id  = s_tdata[17:2];
	assign item.seq      = s_tdata[49:18];
	assign item.now_time = s_tdata[81:50];

	idtq_engine u_engine (
		.clk,
		.arst_n,
		.cfg(cfg_q),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_item(item),
		.res_valid,
		.res_ready,
		.res
	);

	// The output register takes a new result whenever it is empty or being drained.
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = res_q.last;
	assign m_tdata  = {7'b0, res_q.earliest_time, res_q.queue_count, res_q.status,
		res_q.expired, res_q.sequence_out, res_q.conn_id_out};

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the idle timeout deadline queue.
// Depends on idtq_pkg and idle_timeout_deadline_queue_top; drives stream and config ports.
`timescale 1ns / 100ps

module tb_top;
	import idtq_pkg::*;

	localparam int STALL_LIMIT = 40000;

	// One directed stimulus row. When fixed is set, the single result of the
	// row is typed in here and overrides the predicted count and flags.
	typedef struct {
		mode_t       mode;
		logic [15:0] conn;
		logic [31:0] seq;
		logic [31:0] now;
		bit          fixed;
		logic        want_expired;
		logic        want_status;
		logic [6:0]  want_count;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [87:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic        m_tlast;

	// Predictor state: sorted table of deadlines plus the two registers.
	logic [31:0] tab_deadline [QUEUE_DEPTH];
	logic [15:0] tab_conn [QUEUE_DEPTH];
	logic [31:0] tab_seq [QUEUE_DEPTH];
	int          tab_count;
	logic [31:0] tab_head;
	logic [15:0] reg_wait;
	logic        reg_kick;

	res_t        due_reports [$];
	int          n_errors = 0;
	int          send_idle_pct = 21;
	int          recv_idle_pct = 87;
	int          stall_cycles = 0;
	logic [31:0] clock_now = 32'd100;

	idle_timeout_deadline_queue_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #4 clk = ~clk;

	function automatic logic [31:0] deadline_from(logic [31:0] now);
		logic [32:0] sum;
		sum = {1'b0, now} + {17'd0, reg_wait};
		return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	// Insert after every entry whose deadline is less than or equal, so
	// equal deadlines keep arrival order.
	task automatic table_insert(logic [31:0] dl, logic [15:0] conn, logic [31:0] seq);
		int pos;
		pos = 0;
		if (tab_count >= QUEUE_DEPTH) return;
		while (pos < tab_count && tab_deadline[pos] <= dl) pos++;
		for (int i = tab_count; i > pos; i--) begin
			tab_deadline[i] = tab_deadline[i-1];
			tab_conn[i] = tab_conn[i-1];
			tab_seq[i] = tab_seq[i-1];
		end
		tab_deadline[pos] = dl;
		tab_conn[pos] = conn;
		tab_seq[pos] = seq;
		tab_count++;
	endtask

	task automatic table_remove(int pos);
		for (int i = pos; i + 1 < tab_count; i++) begin
			tab_deadline[i] = tab_deadline[i+1];
			tab_conn[i] = tab_conn[i+1];
			tab_seq[i] = tab_seq[i+1];
		end
		tab_count--;
	endtask

	function automatic res_t report(logic [15:0] c, logic [31:0] s, logic e, logic l,
			logic st);
		res_t r;
		r = '0;
		r.conn_id_out = c;
		r.sequence_out = s;
		r.expired = e;
		r.last = l;
		r.status = st;
		return r;
	endfunction

	// Applies one accepted transaction to the predictor and queues the
	// results it must cause.
	task automatic predict_deadlines(row_t it);
		res_t step_res [$];
		int   budget;
		int   idx;
		logic [15:0] c;
		logic [31:0] s;
		res_t r;
		case (it.mode)
			MODE_ADD: begin
				if (tab_count >= QUEUE_DEPTH) begin
					step_res.insert(step_res.size(), report('0, '0, 1'b0, 1'b1, 1'b1));
				end else begin
					table_insert(deadline_from(it.now), it.conn, it.seq);
					tab_head = tab_deadline[0];
					step_res.insert(step_res.size(), report('0, '0, 1'b0, 1'b1, 1'b0));
				end
			end
			MODE_DEL: begin
				idx = 0;
				while (idx < tab_count) begin
					if (tab_conn[idx] == it.conn) table_remove(idx);
					else idx++;
				end
				if (tab_count > 0) tab_head = tab_deadline[0];
				step_res.insert(step_res.size(), report('0, '0, 1'b0, 1'b1, 1'b0));
			end
			MODE_POLL: begin
				// The poll never pops more entries than it found at its start.
				budget = tab_count;
				while (budget > 0 && tab_count > 0 && tab_deadline[0] <= it.now) begin
					c = tab_conn[0];
					s = tab_seq[0];
					table_remove(0);
					if (!reg_kick) table_insert(deadline_from(it.now), c, s);
					if (tab_count > 0) tab_head = tab_deadline[0];
					step_res.insert(step_res.size(), report(c, s, 1'b1, 1'b0, 1'b0));
					budget--;
				end
				if (step_res.size() == 0)
					step_res.insert(step_res.size(), report('0, '0, 1'b0, 1'b1, 1'b0));
				else
					step_res[step_res.size()-1].last = 1'b1;
			end
			default: begin
				tab_count = 0;
				step_res.insert(step_res.size(), report('0, '0, 1'b0, 1'b1, 1'b0));
			end
		endcase
		foreach (step_res[k]) begin
			r = step_res[k];
			r.queue_count = 7'(tab_count);
			r.earliest_time = (tab_count > 0) ? tab_head : 32'd0;
			if (it.fixed) begin
				r.queue_count = it.want_count;
				r.status = it.want_status;
				r.expired = it.want_expired;
			end
			due_reports.insert(due_reports.size(), r);
		end
	endtask

	// Drives one input transaction; called at a rising edge.
	task automatic send_item(row_t it);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, it.now, it.seq, it.conn, it.mode};
		do @(posedge clk); while (!s_tready);
		predict_deadlines(it);
	endtask

	// Quiet the input and wait until every expected result has arrived; the
	// block is idle afterwards and registers may be written.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (due_reports.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_regs(logic [15:0] wt, logic kick);
		cfg_we <= 1'b1;
		cfg_index <= CFG_WAIT_TIME;
		cfg_data <= wt;
		@(posedge clk);
		cfg_index <= CFG_KICK;
		cfg_data <= {15'd0, kick};
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_wait = wt;
		reg_kick = kick;
		@(posedge clk);
	endtask

	function automatic row_t random_row();
		row_t it;
		int   pick;
		it.fixed = 1'b0;
		it.want_expired = 1'b0;
		it.want_status = 1'b0;
		it.want_count = '0;
		pick = $urandom_range(0, 99);
		if (pick < 50) it.mode = MODE_ADD;
		else if (pick < 78) it.mode = MODE_POLL;
		else if (pick < 94) it.mode = MODE_DEL;
		else it.mode = MODE_CLEAR;
		// Mostly a few connections, so deletes and ties hit stored entries.
		if ($urandom_range(0, 9) < 7) it.conn = 16'($urandom_range(0, 7));
		else it.conn = 16'($urandom());
		it.seq = $urandom();
		it.now = clock_now;
		if ($urandom_range(0, 19) == 0) it.now = $urandom();
		return it;
	endfunction

	// Receiver side: random back-pressure on the result stream.
	always @(posedge clk) begin
		if (!arst_n) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Result checker and stall watchdog.
	always @(posedge clk) begin
		res_t want;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (due_reports.size() == 0) begin
				$error("result transaction with nothing expected: %h", m_tdata);
				n_errors++;
			end else begin
				want = due_reports[0];
				due_reports.delete(0);
				if (m_tdata[15:0] !== want.conn_id_out) begin
					$error("conn_id_out expected %h actual %h", want.conn_id_out, m_tdata[15:0]);
					n_errors++;
				end
				if (m_tdata[47:16] !== want.sequence_out) begin
					$error("sequence_out expected %h actual %h", want.sequence_out,
						m_tdata[47:16]);
					n_errors++;
				end
				if (m_tdata[48] !== want.expired) begin
					$error("expired expected %b actual %b", want.expired, m_tdata[48]);
					n_errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last expected %b actual %b", want.last, m_tlast);
					n_errors++;
				end
				if (m_tdata[49] !== want.status) begin
					$error("status expected %b actual %b", want.status, m_tdata[49]);
					n_errors++;
				end
				if (m_tdata[56:50] !== want.queue_count) begin
					$error("queue_count expected %0d actual %0d", want.queue_count,
						m_tdata[56:50]);
					n_errors++;
				end
				if (m_tdata[88:57] !== want.earliest_time) begin
					$error("earliest_time expected %h actual %h", want.earliest_time,
						m_tdata[88:57]);
					n_errors++;
				end
			end
		end
	end

	initial begin
		row_t directed [$];
		row_t it;
		// Reset values of the predictor mirror the block after reset.
		tab_count = 0;
		tab_head = '0;
		reg_wait = 16'd20;
		reg_kick = 1'b0;

		// Directed rows: mode, conn, seq, time, fixed, expired, status, count.
		directed = '{
			'{MODE_POLL,  16'h0000, 32'h0, 32'h0000_0000, 1, 0, 0, 7'd0},
			'{MODE_ADD,   16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0, 7'd1},
			'{MODE_ADD,   16'h0000, 32'h0, 32'h0, 1, 0, 0, 7'd2},
			'{MODE_ADD,   16'h0001, 32'h1, 32'h0, 1, 0, 0, 7'd3},
			'{MODE_ADD,   16'h0002, 32'hA5A5_5A5A, 32'h5, 1, 0, 0, 7'd4},
			'{MODE_POLL,  16'h0000, 32'h0, 32'd19, 1, 0, 0, 7'd4},
			'{MODE_POLL,  16'h0000, 32'h0, 32'd20, 0, 0, 0, 7'd0},
			'{MODE_DEL,   16'hFFFF, 32'h0, 32'h0, 1, 0, 0, 7'd3},
			'{MODE_DEL,   16'h1234, 32'h0, 32'h0, 1, 0, 0, 7'd3},
			'{MODE_POLL,  16'h0000, 32'h0, 32'hFFFF_FFFF, 0, 0, 0, 7'd0},
			'{MODE_POLL,  16'h0000, 32'h0, 32'hFFFF_FFFF, 0, 0, 0, 7'd0},
			'{MODE_CLEAR, 16'h0000, 32'h0, 32'h0, 1, 0, 0, 7'd0},
			'{MODE_POLL,  16'h0000, 32'h0, 32'hFFFF_FFFF, 1, 0, 0, 7'd0},
			'{MODE_ADD,   16'h5555, 32'h5555_5555, 32'hAAAA_AAAA, 0, 0, 0, 7'd0},
			'{MODE_ADD,   16'hAAAA, 32'hAAAA_AAAA, 32'h5555_5555, 0, 0, 0, 7'd0},
			'{MODE_DEL,   16'h5555, 32'h0, 32'h0, 0, 0, 0, 7'd0},
			'{MODE_POLL,  16'h0000, 32'h0, 32'hFFFF_FFFF, 0, 0, 0, 7'd0},
			'{MODE_CLEAR, 16'h0000, 32'h0, 32'h0, 1, 0, 0, 7'd0}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_item(directed[i]);
		drain_results();

		// Each phase sets both registers, then runs random transactions.
		// Phase 3 first fills the table past its depth to reach the drop case.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_regs(16'hFFFF, 1'b0);
				1: write_regs(16'd0, 1'b0);
				2: write_regs(16'd1, 1'b1);
				3: write_regs(16'd3, 1'b1);
				4: write_regs(16'd500, 1'b0);
				default: write_regs(16'd20, 1'b0);
			endcase
			if (ph == 2) begin
				send_idle_pct = 87;
				recv_idle_pct = 21;
			end else if (ph == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (ph == 3) begin
				for (int k = 0; k < QUEUE_DEPTH + 3; k++) begin
					it = random_row();
					it.mode = MODE_ADD;
					it.now = clock_now + 32'($urandom_range(0, 40));
					send_item(it);
				end
			end
			for (int k = 0; k < 16; k++) begin
				clock_now = clock_now + 32'($urandom_range(0, 8));
				send_item(random_row());
			end
			drain_results();
		end

		if (n_errors == 0 && due_reports.size() == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+sv
sv/idtq_pkg.sv
sv/idtq_ram.sv
sv/idtq_engine.sv
sv/idle_timeout_deadline_queue_top.sv
dv/tb_top.sv
